// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  // Opcodes of the input word
  localparam logic [1:0] OP_PUT       = 2'd0;
  localparam logic [1:0] OP_BACKSPACE = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;

  // Configuration register indexes
  localparam logic CFG_FOREGROUND = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [15:0] CELL_BLANK   = 16'h0720;
  localparam logic [15:0] CELL_ZERO    = 16'h0000;
  localparam logic [3:0]  FG_RESET     = 4'd7;
  localparam logic [3:0]  BG_RESET     = 4'd0;

  // Front-to-back queue depth
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_value;
    logic        scrolled;
  } out_word_t;

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_READ,
    CMD_READ_ZERO,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_t;

  // Back-end status
  typedef struct packed {
    logic init_busy;
    logic clearing;
  } stat_t;

endpackage

// ===== hdl/tcw_ram.sv =====
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tcw_front.sv =====
`timescale 1ns / 1ps

module tcw_front #(
  parameter int CELL_COUNT = 2000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcw_pkg::in_word_t in_word_i,
  input  tcw_pkg::stat_t    stat_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output tcw_pkg::cmd_t     push_cmd_o
);

  logic          hold_valid_q, hold_valid_d;
  tcw_pkg::cmd_t hold_cmd_q;
  tcw_pkg::cmd_t cls_cmd;
  logic          accept;

  // Hold stage stalls when the queue is full; no word taken during init
  assign in_stall_o = stat_i.init_busy | (hold_valid_q & ~push_ready_i);
  assign accept     = in_valid_i & ~in_stall_o;

  // Classify the incoming word
  always_comb begin
    cls_cmd.char_code  = in_word_i.char_code;
    cls_cmd.cell_index = in_word_i.cell_index;
    unique case (in_word_i.opcode)
      tcw_pkg::OP_PUT: begin
        cls_cmd.kind = (in_word_i.char_code == tcw_pkg::CHAR_NEWLINE) ?
                       tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_PUT;
      end
      tcw_pkg::OP_BACKSPACE: cls_cmd.kind = tcw_pkg::CMD_BACKSPACE;
      tcw_pkg::OP_READ: begin
        cls_cmd.kind = (32'(in_word_i.cell_index) < CELL_COUNT) ?
                       tcw_pkg::CMD_READ : tcw_pkg::CMD_READ_ZERO;
      end
      default: cls_cmd.kind = tcw_pkg::CMD_NOP;
    endcase
  end

  assign hold_valid_d = accept | (hold_valid_q & ~push_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_cmd_q <= cls_cmd;
    end
  end

  assign push_valid_o = hold_valid_q;
  assign push_cmd_o   = hold_cmd_q;

endmodule

// ===== hdl/tcw_queue.sv =====
`timescale 1ns / 1ps

module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tcw_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output tcw_pkg::cmd_t pop_cmd_o
);

  localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  tcw_pkg::cmd_t   slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CNTW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_i & pop_valid_o;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hdl/tcw_back.sv =====
`timescale 1ns / 1ps

module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         attr_i,
  input  logic               cmd_valid_i,
  input  tcw_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcw_pkg::out_word_t out_word_o,
  output tcw_pkg::stat_t     stat_o
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS);

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      top_base_q, top_base_d;
  logic [AW-1:0]      lin_q, lin_d;
  logic [RW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  tcw_pkg::out_word_t out_q, out_d;
  logic               out_load;
  logic               out_free;
  logic               scrolled;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;

  // Logical linear address to physical: screen rows sit in a ring
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] l,
                                              input logic [AW-1:0] base);
    logic [AW:0] sum;
    sum = (AW+1)'(l) + (AW+1)'(base);
    if (sum >= (AW+1)'(CELL_COUNT)) begin
      sum = sum - (AW+1)'(CELL_COUNT);
    end
    return sum[AW-1:0];
  endfunction

  assign out_free = ~out_valid_q | ~out_stall_i;

  // Command sequencer
  always_comb begin
    state_d    = state_q;
    top_base_d = top_base_q;
    lin_d      = lin_q;
    row_d      = row_q;
    col_d      = col_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    out_load   = 1'b0;
    out_d      = out_q;
    scrolled   = 1'b0;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = phys_addr(lin_q, top_base_q);
    ram_wdata  = {attr_i, cmd_i.char_code};
    ram_raddr  = phys_addr(AW'(cmd_i.cell_index), top_base_q);

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = tcw_pkg::CELL_BLANK;
        if (clr_q == AW'(CELL_COUNT - 1)) begin
          clr_d   = '0;
          state_d = ST_RUN;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_RUN: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind) inside
            tcw_pkg::CMD_PUT, tcw_pkg::CMD_NEWLINE: begin
              ram_we = (cmd_i.kind == tcw_pkg::CMD_PUT);
              if (col_q == CW'(COLUMNS - 1) || cmd_i.kind == tcw_pkg::CMD_NEWLINE) begin
                col_d = '0;
                if (row_q == RW'(ROWS - 1)) begin
                  // Scroll: top row of the ring becomes the cleared bottom row
                  scrolled   = 1'b1;
                  lin_d      = AW'((ROWS - 1) * COLUMNS);
                  top_base_d = (top_base_q == AW'(CELL_COUNT - COLUMNS)) ?
                               '0 : top_base_q + AW'(COLUMNS);
                  clr_d      = top_base_q;
                  cnt_d      = '0;
                  state_d    = ST_CLEAR;
                end else begin
                  row_d = row_q + 1'b1;
                  lin_d = lin_q + (AW'(COLUMNS) - AW'(col_q));
                end
              end else begin
                col_d = col_q + 1'b1;
                lin_d = lin_q + 1'b1;
              end
            end
            tcw_pkg::CMD_BACKSPACE: begin
              if (col_q != '0) begin
                col_d     = col_q - 1'b1;
                lin_d     = lin_q - 1'b1;
                ram_we    = 1'b1;
                ram_waddr = phys_addr(lin_q - 1'b1, top_base_q);
                ram_wdata = {attr_i, tcw_pkg::CHAR_SPACE};
              end
            end
            tcw_pkg::CMD_READ: begin
              state_d = ST_READ;
            end
            default: ;
          endcase
          if (cmd_i.kind != tcw_pkg::CMD_READ) begin
            out_load         = 1'b1;
            out_d.cursor_pos = 11'(lin_d);
            out_d.cell_value = tcw_pkg::CELL_ZERO;
            out_d.scrolled   = scrolled;
          end
        end
      end

      ST_READ: begin
        // Output slot is empty here: it was free when the read was issued
        out_load         = 1'b1;
        out_d.cursor_pos = 11'(lin_q);
        out_d.cell_value = ram_rdata;
        out_d.scrolled   = 1'b0;
        state_d          = ST_RUN;
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = tcw_pkg::CELL_ZERO;
        clr_d     = clr_q + 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CW'(COLUMNS - 1)) begin
          state_d = ST_RUN;
        end
      end

      default: state_d = ST_INIT;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      top_base_q  <= '0;
      lin_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_base_q  <= top_base_d;
      lin_q       <= lin_d;
      row_q       <= row_d;
      col_q       <= col_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign out_word_o       = out_q;
  assign stat_o.init_busy = (state_q == ST_INIT);
  assign stat_o.clearing  = (state_q == ST_CLEAR);

endmodule

// ===== hdl/text_console_char_writer.sv =====
`timescale 1ns / 1ps

// Text console engine: keeps a ROWS x COLUMNS screen of 16-bit cells
// (attribute high byte, character low byte) and a cursor. Put, newline,
// backspace, out-of-range reads and unused opcodes are done in the back
// end's run state; an in-range cell read also passes a read state for the
// registered read of the screen memory. A put or newline that scrolls also
// passes a clear state while the new bottom row is cleared to zero (rows
// live in a ring, so no cells are copied). After reset all ROWS*COLUMNS
// cells (2000 at the defaults) are swept to blank cells; meanwhile no input
// word is taken; configuration writes are taken at any time. A two-entry
// queue sits between the classifying front end and the back end; the result
// word waits in an output register while input fills the queue and hold stage.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcw_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcw_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [3:0]         cfg_data_i
);

  localparam int CELL_COUNT = ROWS * COLUMNS;

  logic [3:0]     fg_q, bg_q;
  tcw_pkg::stat_t stat;
  logic           push_valid, push_ready;
  tcw_pkg::cmd_t  push_cmd;
  logic           q_valid, q_pop;
  tcw_pkg::cmd_t  q_cmd;

  // Color registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcw_pkg::FG_RESET;
      bg_q <= tcw_pkg::BG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tcw_pkg::CFG_FOREGROUND: fg_q <= cfg_data_i;
        tcw_pkg::CFG_BACKGROUND: bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcw_front #(
    .CELL_COUNT (CELL_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .stat_i       (stat),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .attr_i      ({bg_q, fg_q}),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .stat_o      (stat)
  );

  // No input word is taken while the screen is being initialized
  a_init_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.init_busy |-> in_stall_o)
    else $error("input taken during screen init");

  // The back end leaves the queue alone while clearing a row
  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !q_pop)
    else $error("command popped during row clear");

  // A scroll always leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.scrolled) |->
      (out_word_o.cursor_pos == 11'((ROWS - 1) * COLUMNS)))
    else $error("scroll result with wrong cursor");

endmodule
